@@ hw/rtl/dam_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and helpers for the decimal accumulator machine.
// Depends on nothing; every other file of the block uses it.
package dam_pkg;

  // Sizes
  localparam int unsigned MemWords = 100;
  localparam int unsigned AddrW    = 7;
  localparam int unsigned WordW    = 32;
  localparam int unsigned InW      = 15;
  localparam int unsigned CmdW     = 2;
  localparam int unsigned StatW    = 3;
  localparam int unsigned OpW      = 7;
  localparam int unsigned DivCntW  = 5;

  // Decimal split of an instruction word and the legal word range
  localparam logic [WordW-1:0]        DecodeBase = WordW'(100);
  localparam logic signed [WordW-1:0] WordMax    = 32'sd9999;
  localparam logic signed [WordW-1:0] WordMin    = -32'sd9999;
  localparam logic [AddrW-1:0]        LastAddr   = AddrW'(MemWords - 1);
  localparam logic [AddrW-1:0]        MemTop     = AddrW'(MemWords);

  // Opcode split by reciprocal: x / 100 == (x * 5243) >> 19 for every 14-bit x
  localparam int unsigned      DecW     = 14;
  localparam int unsigned      DecShift = 19;
  localparam logic [DecW-1:0]  DecRecip = DecW'(5243);
  localparam logic [WordW-1:0] DecLimit = WordW'(12800);  // lowest word with opcode >= 128

  // Request commands
  typedef enum logic [CmdW-1:0] {
    CMD_LOAD    = 2'd0,
    CMD_STEP    = 2'd1,
    CMD_RESTART = 2'd2
  } dam_cmd_e;

  // Completion status
  typedef enum logic [StatW-1:0] {
    ST_OK        = 3'd0,
    ST_DIV_ZERO  = 3'd1,
    ST_BAD_OP    = 3'd2,
    ST_LOAD_FULL = 3'd3,
    ST_HALTED    = 3'd4
  } dam_status_e;

  // Instruction opcodes
  localparam logic [OpW-1:0] OP_READ   = 7'd10;
  localparam logic [OpW-1:0] OP_WRITE  = 7'd11;
  localparam logic [OpW-1:0] OP_LOAD   = 7'd20;
  localparam logic [OpW-1:0] OP_STORE  = 7'd21;
  localparam logic [OpW-1:0] OP_ADD    = 7'd30;
  localparam logic [OpW-1:0] OP_SUB    = 7'd31;
  localparam logic [OpW-1:0] OP_DIV    = 7'd32;
  localparam logic [OpW-1:0] OP_MUL    = 7'd33;
  localparam logic [OpW-1:0] OP_BRANCH = 7'd40;
  localparam logic [OpW-1:0] OP_BRNEG  = 7'd41;
  localparam logic [OpW-1:0] OP_BRZERO = 7'd42;
  localparam logic [OpW-1:0] OP_HALT   = 7'd43;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_FETCH,
    S_DEC_WAIT,
    S_EXEC,
    S_DIV_WAIT,
    S_RESP
  } dam_state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic capture;
    logic do_load;
    logic do_restart;
    logic step_halted;
    logic rd_pc;
    logic bad_word;
    logic dec_start;
    logic dec_end;
    logic exec;
    logic div_start;
    logic div_end;
    logic rsp_load;
  } dam_ctrl_t;

  // Status from datapath to controller
  typedef struct packed {
    logic [CmdW-1:0] cmd;
    logic            halted;
    logic            word_neg;
    logic            div_busy;
    logic            div_done;
    logic            div_op;
    logic            opd_zero;
  } dam_stat_t;

  // Result payload
  typedef struct packed {
    logic [AddrW-1:0] pc;
    logic [WordW-1:0] acc;
    logic             out_valid;
    logic [WordW-1:0] out_value;
    logic             halted;
    logic [StatW-1:0] status;
  } dam_rsp_t;

  // Clamp a request word to the legal decimal range and widen it
  function automatic logic [WordW-1:0] sat_word(input logic signed [InW-1:0] w);
    logic signed [WordW-1:0] ext;
    ext = WordW'(w);
    if (ext > WordMax) begin
      ext = WordMax;
    end else if (ext < WordMin) begin
      ext = WordMin;
    end
    return ext;
  endfunction

endpackage

@@ hw/rtl/dam_if.sv @@
`timescale 1ns / 1ps
// Request and response channel interfaces of the decimal accumulator machine.
// Depends on dam_pkg for field widths.
interface dam_req_if;
  logic                               valid;
  logic                               ready;
  logic [dam_pkg::CmdW-1:0]           cmd;
  logic signed [dam_pkg::InW-1:0]     word;

  modport source (output valid, cmd, word, input ready);
  modport sink   (input valid, cmd, word, output ready);
endinterface

interface dam_rsp_if;
  logic                               valid;
  logic                               ready;
  logic [dam_pkg::AddrW-1:0]          pc;
  logic signed [dam_pkg::WordW-1:0]   acc;
  logic                               out_valid;
  logic signed [dam_pkg::WordW-1:0]   out_value;
  logic                               halted;
  logic [dam_pkg::StatW-1:0]          status;

  modport source (output valid, pc, acc, out_valid, out_value, halted, status, input ready);
  modport sink   (input valid, pc, acc, out_valid, out_value, halted, status, output ready);
endinterface

@@ hw/rtl/decimal_accumulator_machine.sv @@
`timescale 1ns / 1ps
// Decimal accumulator machine: one request in, one response out, every time.
// A load, restart or unused-command request, and a step while halted, go from
// dispatch straight to the response state. A step reads the instruction word from
// memory, splits it into opcode and operand by reciprocal multiplication over the
// fetch and decode-wait states (the second also reads the operand word) and then
// executes; a negative instruction word stops after the fetch. A divide instruction
// with a nonzero operand runs the bit-serial divider on top. A new request can be
// accepted in the same cycle that a response is raised; a response still waiting
// on the output holds the machine in its last state until it is taken. Program
// memory is 100 words with per-word valid bits, so it is zero after reset with no
// clearing pass.
// Depends on dam_pkg, dam_if, dam_ctrl and dam_dpath.
module decimal_accumulator_machine (
  input  logic        clk_i,
  input  logic        rst_ni,
  dam_req_if.sink     req_i,
  dam_rsp_if.source   rsp_o
);
  import dam_pkg::*;

  dam_ctrl_t ctrl;
  dam_stat_t stat;
  dam_rsp_t  rsp;

  dam_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

  dam_dpath u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .req_cmd_i  (req_i.cmd),
    .req_word_i (req_i.word),
    .stat_o     (stat),
    .rsp_o      (rsp)
  );

  // Drive the response channel from the result register
  assign rsp_o.pc        = rsp.pc;
  assign rsp_o.acc       = rsp.acc;
  assign rsp_o.out_valid = rsp.out_valid;
  assign rsp_o.out_value = rsp.out_value;
  assign rsp_o.halted    = rsp.halted;
  assign rsp_o.status    = rsp.status;

endmodule

@@ hw/rtl/dam_div.sv @@
`timescale 1ns / 1ps
// Iterative unsigned restoring divider, one quotient bit per cycle.
// Depends on dam_pkg; serves the divide opcode on operand magnitudes.
module dam_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [dam_pkg::WordW-1:0]     dividend_i,
  input  logic [dam_pkg::WordW-1:0]     divisor_i,
  output logic                          busy_o,
  output logic                          done_o,
  output logic [dam_pkg::WordW-1:0]     quo_o
);
  import dam_pkg::*;

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [DivCntW-1:0]  cnt_q, cnt_d;
  logic [WordW-1:0]    quo_q, rem_q, dvs_q;
  logic [WordW:0]      shifted;
  logic [WordW+1:0]    diff;
  logic                ge;

  // Trial subtraction of the shifted partial remainder
  assign shifted = {rem_q, quo_q[WordW-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dvs_q};
  assign ge      = ~diff[WordW+1];

  // Sequence the iterations
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
    end else if (busy_q) begin
      cnt_d = cnt_q + DivCntW'(1);
      if (cnt_q == DivCntW'(WordW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Shift in one quotient bit a cycle
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[WordW-1:0] : shifted[WordW-1:0];
      quo_q <= {quo_q[WordW-2:0], ge};
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quo_o  = quo_q;

`ifndef SYNTHESIS
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q))
    else $error("divider finished without running");
`endif

endmodule

@@ hw/rtl/dam_dpath.sv @@
`timescale 1ns / 1ps
// Datapath: program memory, accumulator, counters, divider and result register.
// Depends on dam_pkg and dam_div; driven by dam_ctrl through dam_ctrl_t.
module dam_dpath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  dam_pkg::dam_ctrl_t              ctrl_i,
  input  logic [dam_pkg::CmdW-1:0]        req_cmd_i,
  input  logic signed [dam_pkg::InW-1:0]  req_word_i,
  output dam_pkg::dam_stat_t              stat_o,
  output dam_pkg::dam_rsp_t               rsp_o
);
  import dam_pkg::*;

  // Program memory with per-word valid bits; an unwritten word reads as zero
  logic [WordW-1:0]    mem [MemWords];
  logic [MemWords-1:0] vld_q;
  logic [WordW-1:0]    rdata_q;

  logic [CmdW-1:0]          cmd_q;
  logic signed [InW-1:0]    word_q;
  logic [WordW-1:0]         acc_q, acc_d;
  logic [AddrW-1:0]         pc_q, pc_d, pc_nxt;
  logic [AddrW-1:0]         lp_q, lp_d;
  logic                     halt_q, halt_d;
  logic [StatW-1:0]         status_q, status_d;
  logic                     wrv_q, wrv_d;
  logic [WordW-1:0]         wrval_q, wrval_d;
  logic [OpW-1:0]           op_q;
  logic                     op_big_q;
  logic [AddrW-1:0]         opr_q;
  logic                     neg_q;
  dam_rsp_t                 rsp_q;

  logic                     mem_we;
  logic [AddrW-1:0]         mem_waddr;
  logic [WordW-1:0]         mem_wdata;
  logic                     rd_en;
  logic [AddrW-1:0]         rd_addr;

  logic [DecW-1:0]          dec_word_q;
  logic [OpW-1:0]           dec_quo_q;
  logic                     dec_big_q;
  logic [2*DecW-1:0]        dec_prod;
  logic [DecW-1:0]          dec_rem;

  logic                     div_busy, div_done;
  logic [WordW-1:0]         div_quo;
  logic [WordW-1:0]         acc_abs, m_abs;

  assign pc_nxt  = (pc_q == LastAddr) ? '0 : pc_q + AddrW'(1);
  assign acc_abs = acc_q[WordW-1] ? ('0 - acc_q) : acc_q;
  assign m_abs   = rdata_q[WordW-1] ? ('0 - rdata_q) : rdata_q;

  // Split the instruction word: quotient by reciprocal, then remainder next cycle
  assign dec_prod = rdata_q[DecW-1:0] * DecRecip;
  assign dec_rem  = dec_word_q - DecW'(dec_quo_q * DecodeBase);

  // Divider serves the divide opcode on operand magnitudes
  dam_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (ctrl_i.div_start),
    .dividend_i (acc_abs),
    .divisor_i  (m_abs),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quo_o      (div_quo)
  );

  // Select the memory write: load request, read opcode or store opcode
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = lp_q;
    mem_wdata = sat_word(word_q);
    if (ctrl_i.do_load && (lp_q < MemTop)) begin
      mem_we = 1'b1;
    end
    if (ctrl_i.exec && !op_big_q && (op_q == OP_READ)) begin
      mem_we    = 1'b1;
      mem_waddr = opr_q;
    end
    if (ctrl_i.exec && !op_big_q && (op_q == OP_STORE)) begin
      mem_we    = 1'b1;
      mem_waddr = opr_q;
      mem_wdata = acc_q;
    end
  end

  // Read the instruction word, or the operand word as decode finishes
  assign rd_en   = ctrl_i.rd_pc | ctrl_i.dec_end;
  assign rd_addr = ctrl_i.rd_pc ? pc_q : dec_rem[AddrW-1:0];

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rdata_q <= vld_q[rd_addr] ? mem[rd_addr] : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (mem_we) begin
      vld_q[mem_waddr] <= 1'b1;
    end
  end

  // Architectural state updates
  always_comb begin
    acc_d    = acc_q;
    pc_d     = pc_q;
    lp_d     = lp_q;
    halt_d   = halt_q;
    status_d = status_q;
    wrv_d    = wrv_q;
    wrval_d  = wrval_q;

    if (ctrl_i.capture) begin
      status_d = ST_OK;
      wrv_d    = 1'b0;
      wrval_d  = '0;
    end

    if (ctrl_i.do_load) begin
      if (lp_q < MemTop) begin
        lp_d = lp_q + AddrW'(1);
      end else begin
        status_d = ST_LOAD_FULL;
      end
    end

    if (ctrl_i.do_restart) begin
      pc_d   = '0;
      halt_d = 1'b0;
    end

    if (ctrl_i.step_halted) begin
      status_d = ST_HALTED;
    end

    if (ctrl_i.bad_word) begin
      halt_d   = 1'b1;
      status_d = ST_BAD_OP;
    end

    if (ctrl_i.exec) begin
      if (op_big_q) begin
        halt_d   = 1'b1;
        status_d = ST_BAD_OP;
      end else begin
        case (op_q)
          OP_READ: begin
            pc_d = pc_nxt;
          end
          OP_WRITE: begin
            wrv_d   = 1'b1;
            wrval_d = rdata_q;
            pc_d    = pc_nxt;
          end
          OP_LOAD: begin
            acc_d = rdata_q;
            pc_d  = pc_nxt;
          end
          OP_STORE: begin
            pc_d = pc_nxt;
          end
          OP_ADD: begin
            acc_d = acc_q + rdata_q;
            pc_d  = pc_nxt;
          end
          OP_SUB: begin
            acc_d = acc_q - rdata_q;
            pc_d  = pc_nxt;
          end
          OP_MUL: begin
            acc_d = WordW'(acc_q * rdata_q);
            pc_d  = pc_nxt;
          end
          OP_DIV: begin
            // only reached with a zero divisor
            halt_d   = 1'b1;
            status_d = ST_DIV_ZERO;
          end
          OP_BRANCH: begin
            pc_d = opr_q;
          end
          OP_BRNEG: begin
            pc_d = acc_q[WordW-1] ? opr_q : pc_nxt;
          end
          OP_BRZERO: begin
            pc_d = (acc_q == '0) ? opr_q : pc_nxt;
          end
          OP_HALT: begin
            halt_d = 1'b1;
          end
          default: begin
            halt_d   = 1'b1;
            status_d = ST_BAD_OP;
          end
        endcase
      end
    end

    if (ctrl_i.div_end) begin
      acc_d = neg_q ? ('0 - div_quo) : div_quo;
      pc_d  = pc_nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q    <= '0;
      pc_q     <= '0;
      lp_q     <= '0;
      halt_q   <= 1'b0;
      status_q <= ST_OK;
      wrv_q    <= 1'b0;
      wrval_q  <= '0;
    end else begin
      acc_q    <= acc_d;
      pc_q     <= pc_d;
      lp_q     <= lp_d;
      halt_q   <= halt_d;
      status_q <= status_d;
      wrv_q    <= wrv_d;
      wrval_q  <= wrval_d;
    end
  end

  // Hold the request, the decoded instruction and the result payload
  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      cmd_q  <= req_cmd_i;
      word_q <= req_word_i;
    end
    if (ctrl_i.dec_start) begin
      dec_word_q <= rdata_q[DecW-1:0];
      dec_quo_q  <= dec_prod[DecShift +: OpW];
      dec_big_q  <= (rdata_q >= DecLimit);
    end
    if (ctrl_i.dec_end) begin
      op_q     <= dec_quo_q;
      op_big_q <= dec_big_q;
      opr_q    <= dec_rem[AddrW-1:0];
    end
    if (ctrl_i.div_start) begin
      neg_q <= acc_q[WordW-1] ^ rdata_q[WordW-1];
    end
    if (ctrl_i.rsp_load) begin
      rsp_q.pc        <= pc_q;
      rsp_q.acc       <= acc_q;
      rsp_q.out_valid <= wrv_q;
      rsp_q.out_value <= wrval_q;
      rsp_q.halted    <= halt_q;
      rsp_q.status    <= status_q;
    end
  end

  assign stat_o.cmd      = cmd_q;
  assign stat_o.halted   = halt_q;
  assign stat_o.word_neg = rdata_q[WordW-1];
  assign stat_o.div_busy = div_busy;
  assign stat_o.div_done = div_done;
  assign stat_o.div_op   = !op_big_q && (op_q == OP_DIV);
  assign stat_o.opd_zero = (rdata_q == '0);
  assign rsp_o           = rsp_q;

`ifndef SYNTHESIS
  a_pc_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pc_q <= LastAddr)
    else $error("program counter left the memory");
  a_halt_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(halt_q) |-> $past(ctrl_i.exec || ctrl_i.bad_word))
    else $error("halt set outside instruction execution");
`endif

endmodule

@@ hw/rtl/dam_ctrl.sv @@
`timescale 1ns / 1ps
// Controller state machine: sequences fetch, decode, execute and response.
// Depends on dam_pkg; talks to dam_dpath through dam_ctrl_t and dam_stat_t.
module dam_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 req_valid_i,
  output logic                 req_ready_o,
  output logic                 rsp_valid_o,
  input  logic                 rsp_ready_i,
  input  dam_pkg::dam_stat_t   stat_i,
  output dam_pkg::dam_ctrl_t   ctrl_o
);
  import dam_pkg::*;

  dam_state_e state_q, state_d;
  logic       rsp_valid_q, rsp_valid_d;
  logic       rsp_free;
  logic       accept;

  assign req_ready_o = (state_q == S_IDLE);
  assign accept      = req_valid_i & req_ready_o;
  assign rsp_free    = ~rsp_valid_q | rsp_ready_i;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_DISPATCH;
      end
      S_DISPATCH: begin
        case (stat_i.cmd)
          CMD_STEP: state_d = stat_i.halted ? S_RESP : S_FETCH;
          default:  state_d = S_RESP;
        endcase
      end
      S_FETCH: begin
        state_d = stat_i.word_neg ? S_RESP : S_DEC_WAIT;
      end
      S_DEC_WAIT: begin
        state_d = S_EXEC;
      end
      S_EXEC: begin
        state_d = (stat_i.div_op && !stat_i.opd_zero) ? S_DIV_WAIT : S_RESP;
      end
      S_DIV_WAIT: begin
        if (stat_i.div_done) state_d = S_RESP;
      end
      S_RESP: begin
        if (rsp_free) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Datapath commands
  always_comb begin
    ctrl_o         = '0;
    ctrl_o.capture = accept;
    case (state_q)
      S_DISPATCH: begin
        case (stat_i.cmd)
          CMD_LOAD:    ctrl_o.do_load     = 1'b1;
          CMD_RESTART: ctrl_o.do_restart  = 1'b1;
          CMD_STEP: begin
            ctrl_o.step_halted = stat_i.halted;
            ctrl_o.rd_pc       = ~stat_i.halted;
          end
          default: ;
        endcase
      end
      S_FETCH: begin
        ctrl_o.bad_word  = stat_i.word_neg;
        ctrl_o.dec_start = ~stat_i.word_neg;
      end
      S_DEC_WAIT: begin
        ctrl_o.dec_end = 1'b1;
      end
      S_EXEC: begin
        ctrl_o.div_start = stat_i.div_op & ~stat_i.opd_zero;
        ctrl_o.exec      = ~(stat_i.div_op & ~stat_i.opd_zero);
      end
      S_DIV_WAIT: begin
        ctrl_o.div_end = stat_i.div_done;
      end
      S_RESP: begin
        ctrl_o.rsp_load = rsp_free;
      end
      default: ;
    endcase
  end

  // Response valid: raise on load, drop once taken
  always_comb begin
    rsp_valid_d = rsp_valid_q;
    if (ctrl_o.rsp_load) begin
      rsp_valid_d = 1'b1;
    end else if (rsp_ready_i) begin
      rsp_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  assign rsp_valid_o = rsp_valid_q;

`ifndef SYNTHESIS
  a_rsp_from_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_q) |-> $past(state_q == S_RESP))
    else $error("response raised outside the response state");
  a_div_idle_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.div_start |-> !stat_i.div_busy)
    else $error("divider started while busy");
`endif

endmodule

@@ tb/sv/tb_decimal_accumulator_machine.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the decimal accumulator machine: a boot program, then
// random programs and requests, checked against an in-bench model of the machine.
// Depends on dam_pkg, dam_if and decimal_accumulator_machine.
module tb_decimal_accumulator_machine;
  import dam_pkg::*;

  localparam int PLAN = 0;                 // model copy used while building stimulus
  localparam int LIVE = 1;                 // model copy advanced on accepted requests
  localparam int RandItems = 750;
  localparam int BootWords = 23;
  localparam int HoldAfter = 300;          // results seen before the long hold-off
  localparam int HoldCycles = 400;
  localparam int WatchdogLimit = 4000;
  localparam int TailCycles = 200;
  localparam logic [CmdW-1:0] CmdUnused = 2'd3;
  localparam logic [OpW-1:0]  OpUnlisted = 7'd99;

  typedef struct packed {
    logic [CmdW-1:0] cmd;
    logic [InW-1:0]  word;
    logic            drain;                // hold this request until all results are in
  } machine_req_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  dam_req_if req_if ();
  dam_rsp_if rsp_if ();

  decimal_accumulator_machine i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always #6 clk_i = ~clk_i;

  // Machine state, one copy per view
  logic [WordW-1:0] mem_img  [2][MemWords];
  logic [WordW-1:0] acc_reg  [2];
  logic [AddrW-1:0] pc_reg   [2];
  logic [AddrW-1:0] load_ptr [2];
  logic             halt_reg [2];

  machine_req_t pending_reqs[$];
  dam_rsp_t     expected_rsps[$];
  machine_req_t taken_req;

  int n_offered = 0;
  int n_accepted = 0;
  int n_checked = 0;
  int n_fail = 0;
  int idle_cycles = 0;
  int gap_left = 0;
  int burst_left = 1;
  int stall_left = 0;
  bit stall_done = 1'b0;
  int mode = 0;
  int mode_left = 0;
  bit progress;

  function automatic void machine_reset(int v);
    for (int a = 0; a < MemWords; a++) mem_img[v][a] = '0;
    acc_reg[v]  = '0;
    pc_reg[v]   = '0;
    load_ptr[v] = '0;
    halt_reg[v] = 1'b0;
  endfunction

  // Saturate a request word to the decimal range
  function automatic logic [WordW-1:0] clamp_word(logic signed [InW-1:0] w);
    int s;
    s = int'(w);
    if (s > WordMax) s = WordMax;
    else if (s < WordMin) s = WordMin;
    return WordW'(s);
  endfunction

  // Signed divide that truncates towards zero and wraps on overflow
  function automatic logic [WordW-1:0] quot_trunc(logic [WordW-1:0] num,
                                                  logic [WordW-1:0] den);
    logic [WordW-1:0] mag_n, mag_d, q;
    mag_n = num[WordW-1] ? -num : num;
    mag_d = den[WordW-1] ? -den : den;
    q = mag_n / mag_d;
    return (num[WordW-1] ^ den[WordW-1]) ? -q : q;
  endfunction

  // Apply one request to a model copy and return the response it should give
  function automatic dam_rsp_t machine_exec(int v, logic [CmdW-1:0] cmd,
                                            logic [InW-1:0] word);
    dam_rsp_t r;
    logic [WordW-1:0] instr, opnd;
    logic [AddrW-1:0] cur, tgt;
    int op;
    logic pc_done;
    r = '0;
    r.status = ST_OK;
    cur = pc_reg[v];
    if (cmd == CMD_LOAD) begin
      if (load_ptr[v] < MemTop) begin
        mem_img[v][load_ptr[v]] = clamp_word(word);
        load_ptr[v]++;
      end else begin
        r.status = ST_LOAD_FULL;
      end
    end else if (cmd == CMD_RESTART) begin
      pc_reg[v] = '0;
      halt_reg[v] = 1'b0;
    end else if (cmd == CMD_STEP && halt_reg[v]) begin
      r.status = ST_HALTED;
    end else if (cmd == CMD_STEP) begin
      instr = mem_img[v][cur];
      if (instr[WordW-1]) begin
        // negative word: bad opcode, pc stays
        halt_reg[v] = 1'b1;
        r.status = ST_BAD_OP;
      end else begin
        op = int'(instr / DecodeBase);
        tgt = AddrW'(instr % DecodeBase);
        opnd = mem_img[v][tgt];
        pc_done = 1'b0;
        case (op)
          OP_READ:   mem_img[v][tgt] = clamp_word(word);
          OP_WRITE: begin
            r.out_valid = 1'b1;
            r.out_value = opnd;
          end
          OP_LOAD:   acc_reg[v] = opnd;
          OP_STORE:  mem_img[v][tgt] = acc_reg[v];
          OP_ADD:    acc_reg[v] = acc_reg[v] + opnd;
          OP_SUB:    acc_reg[v] = acc_reg[v] - opnd;
          OP_MUL:    acc_reg[v] = acc_reg[v] * opnd;
          OP_DIV: begin
            if (opnd == '0) begin
              halt_reg[v] = 1'b1;
              r.status = ST_DIV_ZERO;
              pc_done = 1'b1;
            end else begin
              acc_reg[v] = quot_trunc(acc_reg[v], opnd);
            end
          end
          OP_BRANCH: begin
            pc_reg[v] = tgt;
            pc_done = 1'b1;
          end
          OP_BRNEG: begin
            if (acc_reg[v][WordW-1]) begin
              pc_reg[v] = tgt;
              pc_done = 1'b1;
            end
          end
          OP_BRZERO: begin
            if (acc_reg[v] == '0) begin
              pc_reg[v] = tgt;
              pc_done = 1'b1;
            end
          end
          OP_HALT: begin
            halt_reg[v] = 1'b1;
            pc_done = 1'b1;
          end
          default: begin
            halt_reg[v] = 1'b1;
            r.status = ST_BAD_OP;
            pc_done = 1'b1;
          end
        endcase
        if (!pc_done) pc_reg[v] = (cur == LastAddr) ? '0 : cur + 1'b1;
      end
    end
    r.pc = pc_reg[v];
    r.acc = acc_reg[v];
    r.halted = halt_reg[v];
    return r;
  endfunction

  function automatic logic [InW-1:0] encode_instr(logic [OpW-1:0] op, int unsigned opd);
    return InW'(int'(op) * int'(DecodeBase) + opd);
  endfunction

  function automatic logic [InW-1:0] noise_word();
    return InW'($urandom_range(0, (1 << InW) - 1));
  endfunction

  function automatic logic [OpW-1:0] pick_opcode(bit no_branch);
    int unsigned idx;
    idx = no_branch ? $urandom_range(0, 7) : $urandom_range(0, 11);
    case (idx)
      0:       return OP_READ;
      1:       return OP_WRITE;
      2:       return OP_LOAD;
      3:       return OP_STORE;
      4:       return OP_ADD;
      5:       return OP_SUB;
      6:       return OP_DIV;
      7:       return OP_MUL;
      8:       return OP_BRANCH;
      9:       return OP_BRNEG;
      10:      return OP_BRZERO;
      default: return OP_HALT;
    endcase
  endfunction

  // Well-formed instruction; writes never target word 0, which keeps the restart hook
  function automatic logic [InW-1:0] random_instr(bit no_branch);
    logic [OpW-1:0] op;
    op = pick_opcode(no_branch);
    if (op == OP_READ || op == OP_STORE) return encode_instr(op, $urandom_range(1, LastAddr));
    return encode_instr(op, $urandom_range(0, LastAddr));
  endfunction

  function automatic void queue_req(logic [CmdW-1:0] cmd, logic [InW-1:0] word, bit drain);
    machine_req_t q;
    q.cmd = cmd;
    q.word = word;
    q.drain = drain;
    pending_reqs.push_back(q);
    void'(machine_exec(PLAN, cmd, word));
  endfunction

  task automatic check_field(string name, logic [WordW-1:0] want, logic [WordW-1:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%08h, got 0x%08h", name, want, got);
      n_fail++;
    end
  endtask

  // Request driver: bursts with random gaps, holds a drain request until all results are in
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
    end else if (!(req_if.valid && n_accepted != n_offered)) begin
      if (gap_left != 0) begin
        req_if.valid <= 1'b0;
        gap_left--;
      end else if (pending_reqs.size() != 0 &&
                   !(pending_reqs[0].drain && expected_rsps.size() != 0)) begin
        req_if.valid <= 1'b1;
        req_if.cmd   <= pending_reqs[0].cmd;
        req_if.word  <= pending_reqs[0].word;
        n_offered++;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
        end else begin
          burst_left--;
        end
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // Response ready: one long hold-off, otherwise a changing stall pattern
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else if (stall_left != 0) begin
      rsp_if.ready <= 1'b0;
      stall_left--;
    end else if (!stall_done && n_checked >= HoldAfter) begin
      rsp_if.ready <= 1'b0;
      stall_left = HoldCycles;
      stall_done = 1'b1;
    end else begin
      if (mode_left == 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(16, 96);
      end else begin
        mode_left--;
      end
      case (mode)
        0:       rsp_if.ready <= 1'b1;
        1:       rsp_if.ready <= 1'($urandom_range(0, 1));
        2:       rsp_if.ready <= ($urandom_range(0, 7) == 0);
        default: rsp_if.ready <= ~rsp_if.ready;
      endcase
    end
  end

  // Check responses, predict accepted requests, watch for a hang
  always @(posedge clk_i) begin
    if (rst_ni) begin
      progress = 1'b0;
      if (rsp_if.valid && rsp_if.ready) begin
        progress = 1'b1;
        if (expected_rsps.size() == 0) begin
          $error("response with no request outstanding: pc %0d acc 0x%08h",
                 rsp_if.pc, rsp_if.acc);
          n_fail++;
        end else begin
          check_field("pc", WordW'(expected_rsps[0].pc), WordW'(rsp_if.pc));
          check_field("acc", expected_rsps[0].acc, rsp_if.acc);
          check_field("out_valid", WordW'(expected_rsps[0].out_valid),
                      WordW'(rsp_if.out_valid));
          check_field("out_value", expected_rsps[0].out_value, rsp_if.out_value);
          check_field("halted", WordW'(expected_rsps[0].halted), WordW'(rsp_if.halted));
          check_field("status", WordW'(expected_rsps[0].status), WordW'(rsp_if.status));
          void'(expected_rsps.pop_front());
        end
        n_checked++;
      end
      if (req_if.valid && req_if.ready) begin
        progress = 1'b1;
        taken_req = pending_reqs.pop_front();
        expected_rsps.push_back(machine_exec(LIVE, taken_req.cmd, taken_req.word));
        n_accepted++;
      end
      idle_cycles = progress ? 0 : idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("[decimal_accumulator_machine] ERROR");
        $finish;
      end
    end
  end

  initial begin
    logic [InW-1:0] boot_image [BootWords];
    int n_rand;
    int roll;
    bit drain;

    rst_ni = 1'b0;
    req_if.valid = 1'b0;
    req_if.cmd = CMD_LOAD;
    req_if.word = '0;
    rsp_if.ready = 1'b0;
    machine_reset(PLAN);
    machine_reset(LIVE);

    // Boot program: word 0 reads the next instruction into word 1, so each restart
    // can steer the run. Then build INT_MIN, divide it by -1, exercise taken and
    // untaken branches and end on a divide by zero. Data is loaded into words 18..22.
    boot_image = '{
      encode_instr(OP_READ, 1),   encode_instr(OP_BRANCH, 2), encode_instr(OP_LOAD, 18),
      encode_instr(OP_MUL, 18),   encode_instr(OP_MUL, 19),   encode_instr(OP_DIV, 20),
      encode_instr(OP_BRNEG, 8),  encode_instr(OP_HALT, 0),   encode_instr(OP_WRITE, 21),
      encode_instr(OP_ADD, 21),   encode_instr(OP_SUB, 22),   encode_instr(OP_STORE, 23),
      encode_instr(OP_BRZERO, 7), encode_instr(OP_SUB, 23),   encode_instr(OP_BRNEG, 7),
      encode_instr(OP_BRZERO, 17), encode_instr(OP_HALT, 0),  encode_instr(OP_DIV, 24),
      InW'(8192), InW'(32), InW'(-1),
      {1'b0, {(InW-1){1'b1}}}, {1'b1, {(InW-1){1'b0}}}
    };
    for (int i = 0; i < BootWords; i++) queue_req(CMD_LOAD, boot_image[i], 1'b0);
    queue_req(CMD_STEP, encode_instr(OP_BRANCH, 2), 1'b0);
    for (int i = 0; i < 15; i++) queue_req(CMD_STEP, noise_word(), 1'b0);

    // Step and load while halted, then restart into a negative word and an unlisted opcode
    queue_req(CMD_STEP, noise_word(), 1'b0);
    queue_req(CMD_LOAD, encode_instr(OP_WRITE, 21), 1'b0);
    queue_req(CMD_RESTART, noise_word(), 1'b0);
    queue_req(CMD_STEP, InW'(-5), 1'b0);
    queue_req(CMD_STEP, noise_word(), 1'b0);
    queue_req(CMD_RESTART, noise_word(), 1'b0);
    queue_req(CMD_STEP, encode_instr(OpUnlisted, 1), 1'b0);
    queue_req(CMD_STEP, noise_word(), 1'b0);

    // Jump onto the plain halt, then the unused command
    queue_req(CMD_RESTART, noise_word(), 1'b0);
    queue_req(CMD_STEP, encode_instr(OP_BRANCH, 7), 1'b0);
    queue_req(CMD_STEP, noise_word(), 1'b0);
    queue_req(CMD_STEP, noise_word(), 1'b0);
    queue_req(CmdUnused, noise_word(), 1'b0);

    // Random part: finish loading, then mostly well-formed steps with restarts on halt
    n_rand = 0;
    while (n_rand < RandItems) begin
      roll = $urandom_range(0, 99);
      drain = (n_rand == 0 || n_rand == RandItems / 2);
      if (roll < 2) begin
        queue_req(CmdUnused, noise_word(), drain);
      end else begin
        if (load_ptr[PLAN] < MemTop && roll < 50) begin
          queue_req(CMD_LOAD, (roll < 6) ? noise_word() :
                    random_instr(load_ptr[PLAN] == LastAddr), drain);
        end else if (halt_reg[PLAN]) begin
          if (roll < 88) queue_req(CMD_RESTART, noise_word(), drain);
          else if (roll < 95) queue_req(CMD_STEP, noise_word(), drain);
          else queue_req(CMD_LOAD, noise_word(), drain);
        end else if (roll < 5) begin
          queue_req(CMD_RESTART, noise_word(), drain);
        end else if (roll < 8) begin
          queue_req(CMD_LOAD, noise_word(), drain);
        end else begin
          queue_req(CMD_STEP, (roll < 80) ? random_instr(1'b0) : noise_word(), drain);
        end
        n_rand++;
      end
    end

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Drain: every request taken, every result in, then a quiet tail
    while (pending_reqs.size() != 0) @(posedge clk_i);
    while (expected_rsps.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    if (n_fail == 0) begin
      $display("[decimal_accumulator_machine] OK");
    end else begin
      $display("[decimal_accumulator_machine] ERROR");
    end
    $finish;
  end

endmodule
